// ----- src/erpm_pkg.sv -----
package erpm_pkg;

  localparam int unsigned QW = 26;
  localparam int unsigned DW = 24;
  localparam logic [QW-1:0] US_PER_MIN = 26'd60000000;
  localparam logic [15:0] STOP_PERIOD = 16'hFF80;
  localparam logic [7:0] PP_RESET = 8'd7;

  typedef enum logic [2:0] {
    STAT_MOVING  = 3'd0,
    STAT_STOPPED = 3'd1,
    STAT_BADSYM  = 3'd2,
    STAT_CKSUM   = 3'd3,
    STAT_ZPERIOD = 3'd4
  } stat_t;

  typedef struct packed {
    logic [1:0]  chan;
    stat_t       status;
    logic [15:0] period;
    logic        rev;
  } side_t;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] quo;
    logic [DW-1:0] dvsr;
    side_t         side;
  } cell_t;

  // {bad, nibble}
  function automatic logic [4:0] gcr_nib(input logic [4:0] sym);
    logic [4:0] r;
    case (sym)
      5'h09: r = 5'h09;
      5'h0A: r = 5'h0A;
      5'h0B: r = 5'h0B;
      5'h0D: r = 5'h0D;
      5'h0E: r = 5'h0E;
      5'h0F: r = 5'h0F;
      5'h12: r = 5'h02;
      5'h13: r = 5'h03;
      5'h15: r = 5'h05;
      5'h16: r = 5'h06;
      5'h17: r = 5'h07;
      5'h19: r = 5'h00;
      5'h1A: r = 5'h08;
      5'h1B: r = 5'h01;
      5'h1D: r = 5'h04;
      5'h1E: r = 5'h0C;
      default: r = 5'h10;
    endcase
    return r;
  endfunction

endpackage

// ----- src/erpm_telemetry_to_rpm_top.sv -----
// Each frame taken on start yields one result, strobed on done.
// Throughput: one frame per cycle; busy is low except during reset.
// Path: decode stage, divisor multiply stage, 26 restoring division cells, output register.
// Reset (rst, synchronous): clears all valid bits and sets pole_pairs to 7.
// The receiver cannot stall: each result is shown for exactly one cycle.
module erpm_telemetry_to_rpm_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [20:0] raw_frame,
  input  logic [1:0]  channel,
  input  logic        reversed,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output logic        done,
  output logic [1:0]  channel_out,
  output logic [2:0]  status,
  output logic [15:0] period,
  output logic signed [26:0] rpm
);

  localparam int unsigned QW = erpm_pkg::QW;

  logic                  accept;
  logic [7:0]            pole_pairs;
  logic [7:0]            pp_eff;
  logic                  dvalid;
  erpm_pkg::side_t       dside;
  logic                  vch [0:QW];
  erpm_pkg::cell_t       chain [0:QW];
  logic [26:0]           mag;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      pole_pairs <= erpm_pkg::PP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      pole_pairs <= cfg_data;
    end
  end

  assign pp_eff = (pole_pairs == 8'd0) ? 8'd1 : pole_pairs;

  erpm_decode u_dec (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .raw_frame (raw_frame),
    .channel   (channel),
    .reversed  (reversed),
    .dvalid    (dvalid),
    .dside     (dside)
  );

  // (N / p) / pp == N / (p * pp) for truncating division
  always_ff @(posedge clk) begin
    if (rst) begin
      vch[0] <= 1'b0;
    end else begin
      vch[0] <= dvalid;
    end
  end

  always_ff @(posedge clk) begin
    chain[0].rem  <= '0;
    chain[0].quo  <= '0;
    chain[0].dvsr <= erpm_pkg::DW'({8'd0, dside.period} * {16'd0, pp_eff});
    chain[0].side <= dside;
  end

  for (genvar k = 0; k < QW; k++) begin : g_cell
    erpm_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .dbit (erpm_pkg::US_PER_MIN[QW-1-k]),
      .vin  (vch[k]),
      .cin  (chain[k]),
      .vout (vch[k+1]),
      .cout (chain[k+1])
    );
  end

  assign mag = {1'b0, chain[QW].quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vch[QW];
    end
  end

  always_ff @(posedge clk) begin
    channel_out <= chain[QW].side.chan;
    status      <= chain[QW].side.status;
    period      <= chain[QW].side.period;
    if (chain[QW].side.status != erpm_pkg::STAT_MOVING) begin
      rpm <= '0;
    end else if (chain[QW].side.rev) begin
      rpm <= -$signed(mag);
    end else begin
      rpm <= $signed(mag);
    end
  end

endmodule

// ----- src/erpm_decode.sv -----
module erpm_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [20:0]        raw_frame,
  input  logic [1:0]         channel,
  input  logic               reversed,
  output logic               dvalid,
  output erpm_pkg::side_t    dside
);

  logic [20:0] g;
  logic [4:0]  ck, lo, mi, hi;
  logic [11:0] v;
  logic [15:0] per;
  erpm_pkg::side_t side_next;

  always_comb begin
    g   = raw_frame ^ (raw_frame >> 1);
    ck  = erpm_pkg::gcr_nib(g[4:0]);
    lo  = erpm_pkg::gcr_nib(g[9:5]);
    mi  = erpm_pkg::gcr_nib(g[14:10]);
    hi  = erpm_pkg::gcr_nib(g[19:15]);
    v   = {hi[3:0], mi[3:0], lo[3:0]};
    per = 16'(v[8:0]) << v[11:9];
    side_next.chan   = channel;
    side_next.rev    = reversed;
    side_next.period = 16'd0;
    if (raw_frame == 21'd0 || ck[4] || lo[4] || mi[4] || hi[4]) begin
      side_next.status = erpm_pkg::STAT_BADSYM;
    end else if (~(lo[3:0] ^ mi[3:0] ^ hi[3:0]) != ck[3:0]) begin
      side_next.status = erpm_pkg::STAT_CKSUM;
    end else if (per == 16'd0) begin
      side_next.status = erpm_pkg::STAT_ZPERIOD;
    end else if (per == erpm_pkg::STOP_PERIOD) begin
      side_next.status = erpm_pkg::STAT_STOPPED;
      side_next.period = per;
    end else begin
      side_next.status = erpm_pkg::STAT_MOVING;
      side_next.period = per;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvalid <= 1'b0;
    end else begin
      dvalid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    dside <= side_next;
  end

endmodule

// ----- src/erpm_div_cell.sv -----
module erpm_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            dbit,
  input  logic            vin,
  input  erpm_pkg::cell_t cin,
  output logic            vout,
  output erpm_pkg::cell_t cout
);

  logic [erpm_pkg::DW:0] trial;
  logic [erpm_pkg::DW:0] diff;
  logic                  ge;
  erpm_pkg::cell_t       cell_next;

  always_comb begin
    trial = {cin.rem, dbit};
    diff  = trial - {1'b0, cin.dvsr};
    ge    = trial >= {1'b0, cin.dvsr};
    cell_next      = cin;
    cell_next.rem  = ge ? diff[erpm_pkg::DW-1:0] : trial[erpm_pkg::DW-1:0];
    cell_next.quo  = {cin.quo[erpm_pkg::QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    cout <= cell_next;
  end

endmodule

// ----- src/erpm_checker.sv -----
module erpm_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  channel,
  input logic        done,
  input logic [1:0]  channel_out,
  input logic [2:0]  status,
  input logic [15:0] period,
  input logic signed [26:0] rpm
);

  a_done_has_txn: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 29))
    else $error("result without a matching transaction");

  a_chan_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> channel_out == $past(channel, 29))
    else $error("channel tag does not match its transaction");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status == erpm_pkg::STAT_BADSYM || status == erpm_pkg::STAT_CKSUM ||
             status == erpm_pkg::STAT_ZPERIOD)
      |-> period == 16'd0 && rpm == 27'sd0)
    else $error("error result carries non-zero period or rpm");

  a_stop: assert property (@(posedge clk) disable iff (rst)
    done && status == erpm_pkg::STAT_STOPPED
      |-> period == erpm_pkg::STOP_PERIOD && rpm == 27'sd0)
    else $error("stopped result malformed");

endmodule

bind erpm_telemetry_to_rpm_top erpm_checker u_erpm_checker (.*);

// ----- sim/testbench.sv -----
module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 5;
  localparam int ITEMS_PER_PHASE = 110;

  typedef struct packed {
    logic [1:0]         chan;
    erpm_pkg::stat_t    st;
    logic [15:0]        per;
    logic signed [26:0] rpm;
  } rpm_result_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [20:0]        raw_frame;
  logic [1:0]         channel;
  logic               reversed;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [7:0]         cfg_data;
  logic               done;
  logic [1:0]         channel_out;
  logic [2:0]         status;
  logic [15:0]        period;
  logic signed [26:0] rpm;

  rpm_result_t expected_rpm_q[$];
  logic [7:0]  pole_pairs_model;
  int          mismatches = 0;
  int          cycles = 0;
  int          max_gap = 14;

  erpm_telemetry_to_rpm_top DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .raw_frame(raw_frame),
    .channel(channel),
    .reversed(reversed),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .done(done),
    .channel_out(channel_out),
    .status(status),
    .period(period),
    .rpm(rpm)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [4:0] nib_to_sym(input logic [3:0] n);
    logic [4:0] s;
    case (n)
      4'h0: s = 5'h19;
      4'h1: s = 5'h1B;
      4'h2: s = 5'h12;
      4'h3: s = 5'h13;
      4'h4: s = 5'h1D;
      4'h5: s = 5'h15;
      4'h6: s = 5'h16;
      4'h7: s = 5'h17;
      4'h8: s = 5'h1A;
      4'h9: s = 5'h09;
      4'hA: s = 5'h0A;
      4'hB: s = 5'h0B;
      4'hC: s = 5'h1E;
      4'hD: s = 5'h0D;
      4'hE: s = 5'h0E;
      default: s = 5'h0F;
    endcase
    return s;
  endfunction

  // {invalid, nibble}
  function automatic logic [4:0] sym_lookup(input logic [4:0] s);
    logic [4:0] r;
    r = 5'h10;
    for (int n = 0; n < 16; n++)
      if (nib_to_sym(4'(n)) == s) r = {1'b0, 4'(n)};
    return r;
  endfunction

  function automatic logic [20:0] nrzi_encode(input logic [20:0] g);
    logic [20:0] f;
    f[20] = g[20];
    for (int i = 19; i >= 0; i--) f[i] = g[i] ^ f[i+1];
    return f;
  endfunction

  function automatic logic [20:0] gcr_symbols(input logic [11:0] v, input logic [3:0] ck_err,
                                              input logic top);
    logic [3:0] ck;
    ck = ~(v[11:8] ^ v[7:4] ^ v[3:0]) ^ ck_err;
    return {top, nib_to_sym(v[11:8]), nib_to_sym(v[7:4]), nib_to_sym(v[3:0]), nib_to_sym(ck)};
  endfunction

  function automatic logic [20:0] telemetry_frame(input logic [11:0] v, input logic [3:0] ck_err,
                                                  input logic top);
    return nrzi_encode(gcr_symbols(v, ck_err, top));
  endfunction

  function automatic logic [20:0] bad_symbol_frame(input logic [11:0] v, input int slot,
                                                   input logic top);
    logic [20:0] g;
    logic [4:0]  s;
    logic [4:0]  d;
    g = gcr_symbols(v, 4'h0, top);
    do begin
      s = 5'($urandom_range(0, 31));
      d = sym_lookup(s);
    end while (!d[4]);
    g[slot*5 +: 5] = s;
    return nrzi_encode(g);
  endfunction

  function automatic rpm_result_t predict_rpm(input logic [20:0] f, input logic [1:0] ch,
                                              input logic rev);
    rpm_result_t r;
    logic [20:0] g;
    logic [4:0]  d;
    logic [3:0]  nib [4];
    logic        invalid;
    logic [11:0] v;
    int unsigned per_us;
    int unsigned pp;
    logic [26:0] mag;
    r.chan = ch;
    r.st = erpm_pkg::STAT_BADSYM;
    r.per = '0;
    r.rpm = '0;
    if (f == '0) return r;
    g = f ^ (f >> 1);
    invalid = 1'b0;
    for (int i = 0; i < 4; i++) begin
      d = sym_lookup(g[i*5 +: 5]);
      invalid |= d[4];
      nib[i] = d[3:0];
    end
    if (invalid) return r;
    if ((~(nib[1] ^ nib[2] ^ nib[3]) & 4'hF) != nib[0]) begin
      r.st = erpm_pkg::STAT_CKSUM;
      return r;
    end
    v = {nib[3], nib[2], nib[1]};
    per_us = int'(v[8:0]) << v[11:9];
    if (per_us == 0) begin
      r.st = erpm_pkg::STAT_ZPERIOD;
    end else if (per_us == int'(erpm_pkg::STOP_PERIOD)) begin
      r.st = erpm_pkg::STAT_STOPPED;
      r.per = 16'(per_us);
    end else begin
      pp = (pole_pairs_model == 0) ? 1 : pole_pairs_model;
      mag = 27'((60000000 / per_us) / pp);
      r.st = erpm_pkg::STAT_MOVING;
      r.per = 16'(per_us);
      r.rpm = rev ? -mag : mag;
    end
    return r;
  endfunction

  task automatic send_frame(input logic [20:0] f, input logic [1:0] ch, input logic rev);
    int gap;
    gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    raw_frame = f;
    channel = ch;
    reversed = rev;
    do @(posedge clk); while (busy);
    expected_rpm_q.push_back(predict_rpm(f, ch, rev));
  endtask

  task automatic drain_results;
    @(negedge clk);
    start = 1'b0;
    while (expected_rpm_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_pole_pairs(input logic [7:0] pp);
    drain_results();
    repeat ($urandom_range(0, 3)) @(negedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = pp;
    do @(posedge clk); while (!cfg_ready);
    pole_pairs_model = pp;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_frame_decode;
    max_gap = 0;
    send_frame(21'h000000, 2'd0, 1'b0);
    send_frame(21'h1FFFFF, 2'd1, 1'b1);
    send_frame(telemetry_frame(12'h001, 4'h0, 1'b1), 2'd2, 1'b0);
    send_frame(telemetry_frame(12'h001, 4'h0, 1'b0), 2'd3, 1'b1);
    send_frame(telemetry_frame({3'd7, 9'h001}, 4'h0, 1'b1), 2'd0, 1'b0);
    send_frame(telemetry_frame({3'd7, 9'h1FF}, 4'h0, 1'b1), 2'd1, 1'b1);
    send_frame(telemetry_frame({3'd7, 9'h1FE}, 4'h0, 1'b0), 2'd2, 1'b1);
    max_gap = 14;
    send_frame(telemetry_frame({3'd0, 9'h1FF}, 4'h0, 1'b1), 2'd3, 1'b0);
    send_frame(telemetry_frame({3'd3, 9'h000}, 4'h0, 1'b1), 2'd0, 1'b1);
    send_frame(telemetry_frame(12'h5A3, 4'h1, 1'b1), 2'd1, 1'b0);
    send_frame(telemetry_frame(12'h0C7, 4'hF, 1'b0), 2'd2, 1'b0);
    for (int slot = 0; slot < 4; slot++)
      send_frame(bad_symbol_frame(12'($urandom), slot, 1'b1), 2'(slot), 1'($urandom));
  endtask

  task automatic test_pole_pairs;
    write_pole_pairs(8'd1);
    send_frame(telemetry_frame(12'h001, 4'h0, 1'b1), 2'd0, 1'b1);
    send_frame(telemetry_frame(12'h001, 4'h0, 1'b1), 2'd1, 1'b0);
    write_pole_pairs(8'd255);
    send_frame(telemetry_frame(12'h001, 4'h0, 1'b1), 2'd2, 1'b0);
    send_frame(telemetry_frame({3'd7, 9'h1FE}, 4'h0, 1'b1), 2'd3, 1'b1);
    write_pole_pairs(8'd0);
    send_frame(telemetry_frame(12'h001, 4'h0, 1'b1), 2'd0, 1'b1);
    send_frame(telemetry_frame(12'($urandom), 4'h0, 1'b0), 2'd1, 1'b0);
  endtask

  task automatic test_random_traffic;
    logic [11:0] v;
    logic [20:0] f;
    logic        top;
    logic [7:0]  pp;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: pp = 8'd255;
        3: pp = 8'd1;
        default: pp = 8'($urandom_range(0, 255));
      endcase
      write_pole_pairs(pp);
      max_gap = (ph == 2) ? 0 : 14;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        v = 12'($urandom);
        top = 1'($urandom);
        case ($urandom_range(0, 19))
          14, 15: f = telemetry_frame(v, 4'($urandom_range(1, 15)), top);
          16, 17: f = bad_symbol_frame(v, $urandom_range(0, 3), top);
          18: f = 21'($urandom);
          19: begin
            case ($urandom_range(0, 2))
              0: v = {3'd7, 9'h1FF};
              1: v[8:0] = 9'h000;
              default: v = {3'd0, 9'($urandom_range(1, 3))};
            endcase
            f = telemetry_frame(v, 4'h0, top);
          end
          default: f = telemetry_frame(v, 4'h0, top);
        endcase
        send_frame(f, 2'($urandom), 1'($urandom));
      end
    end
  endtask

  always @(posedge clk) begin
    rpm_result_t want;
    if (!rst && done) begin
      if (expected_rpm_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: ch %0d status %0d period %0d rpm %0d",
                   channel_out, status, period, rpm);
      end else begin
        want = expected_rpm_q.pop_front();
        if (channel_out !== want.chan || status !== want.st || period !== want.per ||
            rpm !== want.rpm) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: got ch %0d status %0d period %0d rpm %0d, ",
                      "want ch %0d status %0d period %0d rpm %0d"},
                     channel_out, status, period, rpm,
                     want.chan, want.st, want.per, want.rpm);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("erpm_telemetry_to_rpm_top test failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    raw_frame = '0;
    channel = '0;
    reversed = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    pole_pairs_model = erpm_pkg::PP_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_frame_decode();
    test_pole_pairs();
    test_random_traffic();

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("erpm_telemetry_to_rpm_top test passed");
    end else begin
      $display("erpm_telemetry_to_rpm_top test failed");
    end
    $finish;
  end

endmodule
